/* rtl/cds_pkg.sv */
// package: shared types, constants and helpers for the clock divider search
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

   // divider unit operand widths
   localparam int unsigned DVD_W = 31;
   localparam int unsigned DSR_W = 32;

   // divider word fields
   localparam logic [31:0] SLOW_WORD   = 32'h7FFF_F000;
   localparam logic [31:0] BYPASS_WORD = 32'h8000_0000;
   localparam logic [5:0]  MAX_N       = 6'h3F;
   localparam logic [12:0] MAX_PRE     = 13'h1FFF;

   // slowest reachable frequency is ref / (8192 * 64)
   localparam int unsigned SLOW_SHIFT = 19;

   // outcome codes
   localparam logic [2:0] OUT_BYPASS = 3'd0;
   localparam logic [2:0] OUT_SLOW   = 3'd1;
   localparam logic [2:0] OUT_EXACT  = 3'd2;
   localparam logic [2:0] OUT_BELOW  = 3'd3;
   localparam logic [2:0] OUT_NONE   = 3'd4;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } cds_div_cmd_type;

   typedef struct packed {
      logic             done;
      logic             busy;
      logic [DVD_W-1:0] quotient;
   } cds_div_sts_type;

   // pack prescaler and count into the clock register word
   function automatic logic [31:0] make_word(input logic [12:0] pre, input logic [5:0] n);
      logic [6:0] n_inc;
      logic [6:0] low;
      n_inc = {1'b0, n} + 7'd1;
      low   = n_inc >> 1;
      return {1'b0, pre, n, 6'd0, low[5:0]};
   endfunction

endpackage

`default_nettype wire

/* rtl/cds_req_if.sv */
// interface: request channel carrying the wanted frequency
`timescale 1ns / 1ps
`default_nettype none

interface cds_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] want_freq;

   modport source (output valid, output want_freq, input ready);
   modport sink (input valid, input want_freq, output ready);
endinterface

`default_nettype wire

/* rtl/cds_rsp_if.sv */
// interface: response channel carrying the divider word and its frequency
`timescale 1ns / 1ps
`default_nettype none

interface cds_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] divider_word;
   logic [30:0] got_freq;
   logic [2:0]  outcome;

   modport source (output valid, output divider_word, output got_freq, output outcome,
                   input ready);
   modport sink (input valid, input divider_word, input got_freq, input outcome,
                 output ready);
endinterface

`default_nettype wire

/* rtl/cds_divider.sv */
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module cds_divider
   import cds_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cds_div_cmd_type div_cmd,
   output cds_div_sts_type      div_sts
);

   localparam int unsigned CNT_W = $clog2(DVD_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;

   logic [DSR_W:0]   shifted;
   logic [DSR_W:0]   diff;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = shifted >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (!busy_ff) begin
         if (div_cmd.start) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            rem_in  = '0;
            quo_in  = div_cmd.dividend;
            dsr_in  = div_cmd.divisor;
         end
      end else begin
         rem_in = fits ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_sts.done     = done_ff;
   assign div_sts.busy     = busy_ff;
   assign div_sts.quotient = quo_ff;

`ifndef SYNTHESIS
   // remainder ends below the divisor
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ({1'b0, rem_ff} < {1'b0, dsr_ff}))
      else $error("divider remainder not reduced");

   // a start while idle begins a fresh pass
   a_start: assert property (@(posedge clock) disable iff (reset)
      (div_cmd.start && !busy_ff) |=> (busy_ff && cnt_ff == '0))
      else $error("divider did not start");

   // done is a single pulse and never overlaps busy
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff ##1 !done_ff))
      else $error("divider done not a clean pulse");
`endif

endmodule

`default_nettype wire

/* rtl/clock_divider_search_top.sv */
// top level: serial clock divider search with a shared iterative divider
//
//   channel   dir  handshake        beat contents
//   req_chan  in   valid / ready    want_freq [31:0]
//   rsp_chan  out  valid / ready    divider_word [31:0], got_freq [30:0], outcome [2:0]
//   csr       in   csr_wr_en        csr_wr_data [30:0] -> reference clock in hertz
//
// one request at a time; req_chan.ready is high only while the search is idle
// bypass and slowest-clamp requests go from idle straight to the response state
// a full search takes 6 divisions per N over N = 1..63, each division
//   31 steps of the shared divider
// an exact hit stops the search early at the end of that trial
// reset is synchronous, clears the sequencer and loads the reference clock to 80 MHz
// the result sits in the response registers until rsp_chan.ready takes the beat
`timescale 1ns / 1ps
`default_nettype none

module clock_divider_search_top
   import cds_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [30:0] csr_wr_data,
   cds_req_if.sink          req_chan,
   cds_rsp_if.source        rsp_chan
);

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_N_GO   = 4'd1;  // ref / (N+1)
   localparam logic [3:0] S_N_WAIT = 4'd2;
   localparam logic [3:0] S_Q_GO   = 4'd3;  // (ref / (N+1)) / want
   localparam logic [3:0] S_Q_WAIT = 4'd4;
   localparam logic [3:0] S_T_SET  = 4'd5;  // clamp guess, form (pre+1)*(N+1)
   localparam logic [3:0] S_T_GO   = 4'd6;  // ref / ((pre+1)*(N+1))
   localparam logic [3:0] S_T_WAIT = 4'd7;
   localparam logic [3:0] S_RESP   = 4'd8;

   // upper edge of the clamp on q + guess offset, before the offset of -2
   localparam logic [31:0] CLAMP_HI = 32'd8193;
   localparam logic [31:0] CLAMP_LO = 32'd2;

   logic [3:0]  state_ff, state_in;
   logic [30:0] ref_clk_ff;
   logic [31:0] want_ff, want_in;
   logic [5:0]  n_ff, n_in;
   logic [1:0]  vi_ff, vi_in;
   logic [30:0] cq_ff, cq_in;          // ref / (N+1)
   logic [30:0] q_ff, q_in;            // cq / want
   logic [12:0] pre_ff, pre_in;
   logic [19:0] prod_ff, prod_in;
   logic [31:0] word_ff, word_in;
   logic [30:0] freq_ff, freq_in;
   logic [2:0]  outcome_ff, outcome_in;

   cds_div_cmd_type div_cmd;
   cds_div_sts_type div_sts;

   // guess clamp and divisor for the current trial
   logic [31:0] guess_sum;
   logic [12:0] pre_calc;
   logic [13:0] pre_inc;
   logic [6:0]  n_inc;
   logic [19:0] prod_calc;

   // trial compare
   logic [30:0] trial_freq;
   logic        trial_hit;
   logic        trial_better;

   assign guess_sum = {1'b0, q_ff} + {30'd0, vi_ff};

   always_comb begin
      if (guess_sum > CLAMP_HI) begin
         pre_calc = MAX_PRE;
      end else if (guess_sum <= CLAMP_LO) begin
         pre_calc = '0;
      end else begin
         pre_calc = guess_sum[12:0] - 13'd2;
      end
   end

   // (pre+1)*(N+1) is at most 8192 * 64, so 20 bits hold it
   assign pre_inc   = {1'b0, pre_calc} + 14'd1;
   assign n_inc     = {1'b0, n_ff} + 7'd1;
   assign prod_calc = {6'd0, pre_inc} * {13'd0, n_inc};

   assign trial_freq   = div_sts.quotient;
   assign trial_hit    = {1'b0, trial_freq} == want_ff;
   assign trial_better = ({1'b0, trial_freq} < want_ff) && (trial_freq > freq_ff);

   // divider operand select
   always_comb begin
      div_cmd.start    = 1'b0;
      div_cmd.dividend = ref_clk_ff;
      div_cmd.divisor  = {25'd0, n_inc};
      unique case (state_ff)
         S_N_GO: begin
            div_cmd.start = 1'b1;
         end
         S_Q_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = cq_ff;
            div_cmd.divisor  = want_ff;
         end
         S_T_GO: begin
            div_cmd.start   = 1'b1;
            div_cmd.divisor = {12'd0, prod_ff};
         end
         default: begin
            div_cmd.start = 1'b0;
         end
      endcase
   end

   cds_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .div_sts (div_sts)
   );

   // sequencer
   always_comb begin
      state_in   = state_ff;
      want_in    = want_ff;
      n_in       = n_ff;
      vi_in      = vi_ff;
      cq_in      = cq_ff;
      q_in       = q_ff;
      pre_in     = pre_ff;
      prod_in    = prod_ff;
      word_in    = word_ff;
      freq_in    = freq_ff;
      outcome_in = outcome_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               want_in = req_chan.want_freq;
               if (req_chan.want_freq >= {1'b0, ref_clk_ff}) begin
                  // at or above the reference: pass it straight through
                  word_in    = BYPASS_WORD;
                  freq_in    = '0;
                  outcome_in = OUT_BYPASS;
                  state_in   = S_RESP;
               end else if (req_chan.want_freq == '0 ||
                            req_chan.want_freq < {20'd0, ref_clk_ff[30:SLOW_SHIFT]}) begin
                  // below the slowest reachable clock
                  word_in    = SLOW_WORD;
                  freq_in    = {19'd0, ref_clk_ff[30:SLOW_SHIFT]};
                  outcome_in = OUT_SLOW;
                  state_in   = S_RESP;
               end else begin
                  word_in    = '0;
                  freq_in    = '0;
                  outcome_in = OUT_NONE;
                  n_in       = 6'd1;
                  state_in   = S_N_GO;
               end
            end
         end
         S_N_GO: begin
            state_in = S_N_WAIT;
         end
         S_N_WAIT: begin
            if (div_sts.done) begin
               cq_in    = div_sts.quotient;
               state_in = S_Q_GO;
            end
         end
         S_Q_GO: begin
            state_in = S_Q_WAIT;
         end
         S_Q_WAIT: begin
            if (div_sts.done) begin
               q_in     = div_sts.quotient;
               vi_in    = '0;
               state_in = S_T_SET;
            end
         end
         S_T_SET: begin
            pre_in   = pre_calc;
            prod_in  = prod_calc;
            state_in = S_T_GO;
         end
         S_T_GO: begin
            state_in = S_T_WAIT;
         end
         S_T_WAIT: begin
            if (div_sts.done) begin
               if (trial_hit) begin
                  word_in    = make_word(pre_ff, n_ff);
                  freq_in    = trial_freq;
                  outcome_in = OUT_EXACT;
                  state_in   = S_RESP;
               end else begin
                  if (trial_better) begin
                     word_in    = make_word(pre_ff, n_ff);
                     freq_in    = trial_freq;
                     outcome_in = OUT_BELOW;
                  end
                  if (vi_ff != 2'd3) begin
                     vi_in    = vi_ff + 2'd1;
                     state_in = S_T_SET;
                  end else if (n_ff == MAX_N) begin
                     state_in = S_RESP;
                  end else begin
                     n_in     = n_ff + 6'd1;
                     state_in = S_N_GO;
                  end
               end
            end
         end
         S_RESP: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ref_clk_ff <= 31'd80000000;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            ref_clk_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      want_ff    <= want_in;
      n_ff       <= n_in;
      vi_ff      <= vi_in;
      cq_ff      <= cq_in;
      q_ff       <= q_in;
      pre_ff     <= pre_in;
      prod_ff    <= prod_in;
      word_ff    <= word_in;
      freq_ff    <= freq_in;
      outcome_ff <= outcome_in;
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = (state_ff == S_RESP);
   assign rsp_chan.divider_word = word_ff;
   assign rsp_chan.got_freq     = freq_ff;
   assign rsp_chan.outcome      = outcome_ff;

`ifndef SYNTHESIS
   // an exact answer reports the requested frequency
   a_exact: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && outcome_ff == OUT_EXACT) |-> ({1'b0, freq_ff} == want_ff))
      else $error("exact result does not match request");

   // a closest-below answer stays strictly under the request
   a_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && outcome_ff == OUT_BELOW) |->
         ({1'b0, freq_ff} < want_ff && freq_ff != '0))
      else $error("closest result not below request");

   // no candidate found leaves an all-zero answer
   a_none: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && outcome_ff == OUT_NONE) |-> (word_ff == '0 && freq_ff == '0))
      else $error("empty result carries data");

   // the divider is only started while it is free
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_sts.busy)
      else $error("divider started while busy");
`endif

endmodule

`default_nettype wire
